>>> rtl/sha_pkg.sv
// ----------------------------------------------------------------------------
// sha_pkg
// Shared types and constants of the SHA-256 stream hasher: word type,
// sequencer states, initial hash value and round constants.
// ----------------------------------------------------------------------------
package sha_pkg;

    typedef logic [31:0] t_word;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_COMP,
        ST_PAD1,
        ST_PAD2,
        ST_OUT,
        ST_ERR
    } t_state;

    localparam int unsigned MIN_ROOM = 32;
    localparam logic [7:0]  PAD_BYTE = 8'h80;

    localparam t_word INIT_HASH [8] = '{
        32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
        32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
    };

    localparam t_word ROUND_K [64] = '{
        32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
        32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
        32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
        32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
        32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
        32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
        32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
        32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
        32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
        32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
        32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
        32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
        32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
        32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
        32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
        32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
    };

endpackage

>>> rtl/sha256_stream_hasher.sv
// ----------------------------------------------------------------------------
// sha256_stream_hasher
// Byte-stream SHA-256 hasher with padding, length tracking and digest output.
// ----------------------------------------------------------------------------
// A data byte is accepted while the hasher is idle; each 64th byte starts a block
// compression (a start, 64 rounds in one shared round unit, then a fold into
// the chain) during which input is stalled. A finish word that is not an error
// finish runs one or two such compressions (two when 56 or more bytes sit in
// the block) and then presents eight digest words, most significant first, one
// per accepted output word; an error finish presents a single word. The hasher
// then restarts on the standard initial value.
module sha256_stream_hasher (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [7:0]  i_cfg_wdata,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic        i_mode,
    input  logic [7:0]  i_data_byte,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [31:0] o_digest_word,
    output logic [2:0]  o_word_index,
    output logic        o_status,
    output logic        o_last_word
);
    import sha_pkg::*;

    t_state      r_state, n_state;
    t_word       r_blk [16];
    t_word       pad_blk [16];
    t_word       len_blk [16];
    t_word       chain [8];
    logic [7:0]  r_room;
    logic [5:0]  r_fill;
    logic [63:0] r_bits;
    logic        r_corrupt;
    logic [2:0]  r_idx;
    logic        core_init, core_done;
    logic        in_acc, out_acc;
    logic        r_go;

    sha_core u_core (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (r_go),
        .i_init  (core_init),
        .i_blk   (r_blk),
        .o_done  (core_done),
        .o_chain (chain)
    );

    assign in_acc  = i_in_valid && !o_in_stall;
    assign out_acc = o_out_valid && !i_out_stall;

    // pad: keep bytes below fill, marker at fill, zero above
    always_comb begin
        for (int j = 0; j < 64; j++) begin
            if (6'(j) < r_fill) begin
                pad_blk[j/4][31-8*(j%4) -: 8] = r_blk[j/4][31-8*(j%4) -: 8];
            end else if (6'(j) == r_fill) begin
                pad_blk[j/4][31-8*(j%4) -: 8] = PAD_BYTE;
            end else begin
                pad_blk[j/4][31-8*(j%4) -: 8] = 8'h00;
            end
        end
        len_blk     = pad_blk;
        len_blk[14] = r_bits[63:32];
        len_blk[15] = r_bits[31:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state   = r_state;
        core_init = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                if (in_acc) begin
                    if (i_mode) begin
                        if (r_corrupt || r_room < 8'(MIN_ROOM)) begin
                            n_state = ST_ERR;
                        end else begin
                            n_state = (r_fill >= 6'd56) ? ST_PAD1 : ST_PAD2;
                        end
                    end else if (!r_corrupt && !(&r_bits[63:3]) && r_fill == 6'd63) begin
                        n_state = ST_COMP;
                    end
                end
            end
            ST_COMP: if (core_done) n_state = ST_IDLE;
            ST_PAD1: if (core_done) n_state = ST_PAD2;
            ST_PAD2: if (core_done) n_state = ST_OUT;
            ST_OUT: begin
                if (out_acc && r_idx == 3'd7) begin
                    n_state   = ST_IDLE;
                    core_init = 1'b1;
                end
            end
            ST_ERR: begin
                if (out_acc) begin
                    n_state   = ST_IDLE;
                    core_init = 1'b1;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // start a compression on the cycle after the block is staged
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_go <= 1'b0;
        end else begin
            r_go <= (r_state != n_state) &&
                    (n_state == ST_COMP || n_state == ST_PAD1 || n_state == ST_PAD2);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_room    <= 8'(MIN_ROOM);
            r_fill    <= '0;
            r_bits    <= '0;
            r_corrupt <= 1'b0;
            r_idx     <= '0;
        end else begin
            if (i_cfg_we) begin
                r_room <= i_cfg_wdata;
            end
            if (r_state == ST_IDLE && in_acc) begin
                if (i_mode) begin
                    if (!(r_corrupt || r_room < 8'(MIN_ROOM))) begin
                        r_blk <= (r_fill >= 6'd56) ? pad_blk : len_blk;
                    end
                end else if (!r_corrupt) begin
                    if (&r_bits[63:3]) begin
                        r_corrupt <= 1'b1;
                    end else begin
                        r_bits <= r_bits + 64'd8;
                        r_blk[r_fill[5:2]][31-8*r_fill[1:0] -: 8] <= i_data_byte;
                        r_fill <= r_fill + 6'd1;
                    end
                end
            end
            if (r_state == ST_PAD1 && core_done) begin
                for (int i = 0; i < 14; i++) r_blk[i] <= '0;
                r_blk[14] <= r_bits[63:32];
                r_blk[15] <= r_bits[31:0];
            end
            if (r_state == ST_OUT && out_acc) begin
                r_idx <= r_idx + 3'd1;
            end
            if (core_init) begin
                r_fill    <= '0;
                r_bits    <= '0;
                r_corrupt <= 1'b0;
                r_idx     <= '0;
            end
        end
    end

    assign o_in_stall    = (r_state != ST_IDLE) || r_go;
    assign o_out_valid   = (r_state == ST_OUT) || (r_state == ST_ERR);
    assign o_status      = (r_state == ST_ERR);
    assign o_digest_word = o_status ? 32'd0 : chain[r_idx];
    assign o_word_index  = o_status ? 3'd0 : r_idx;
    assign o_last_word   = o_status || (r_idx == 3'd7);

endmodule

>>> rtl/sha_core.sv
// ----------------------------------------------------------------------------
// sha_core
// Iterative SHA-256 compression: one round per cycle for 64 rounds with a
// rolling 16-word message schedule, then a fold into the chain.
// ----------------------------------------------------------------------------
module sha_core (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_start,
    input  logic                i_init,
    input  sha_pkg::t_word      i_blk [16],
    output logic                o_done,
    output sha_pkg::t_word      o_chain [8]
);
    import sha_pkg::*;

    t_word      r_h [8];
    t_word      r_v [8];
    t_word      r_w [16];
    logic [5:0] r_rnd;
    logic       r_busy;
    logic       r_add;

    t_word s0, s1, w_new, t1, t2, sig0, sig1, ch, maj;

    function automatic t_word rotr(input t_word x, input int unsigned n);
        rotr = (x >> n) | (x << (32 - n));
    endfunction

    always_comb begin
        s0    = rotr(r_w[1], 7) ^ rotr(r_w[1], 18) ^ (r_w[1] >> 3);
        s1    = rotr(r_w[14], 17) ^ rotr(r_w[14], 19) ^ (r_w[14] >> 10);
        w_new = r_w[0] + s0 + r_w[9] + s1;
        sig1  = rotr(r_v[4], 6) ^ rotr(r_v[4], 11) ^ rotr(r_v[4], 25);
        ch    = (r_v[4] & r_v[5]) ^ (~r_v[4] & r_v[6]);
        sig0  = rotr(r_v[0], 2) ^ rotr(r_v[0], 13) ^ rotr(r_v[0], 22);
        maj   = (r_v[0] & r_v[1]) ^ (r_v[0] & r_v[2]) ^ (r_v[1] & r_v[2]);
        t1    = r_v[7] + sig1 + ch + ROUND_K[r_rnd] + r_w[0];
        t2    = sig0 + maj;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_add  <= 1'b0;
            r_rnd  <= '0;
            r_h    <= INIT_HASH;
        end else begin
            r_add <= 1'b0;
            if (i_init) begin
                r_h <= INIT_HASH;
            end
            if (i_start) begin
                r_busy <= 1'b1;
                r_rnd  <= '0;
                r_v    <= r_h;
                r_w    <= i_blk;
            end else if (r_busy) begin
                for (int i = 0; i < 15; i++) r_w[i] <= r_w[i+1];
                r_w[15] <= w_new;
                r_v[7]  <= r_v[6];
                r_v[6]  <= r_v[5];
                r_v[5]  <= r_v[4];
                r_v[4]  <= r_v[3] + t1;
                r_v[3]  <= r_v[2];
                r_v[2]  <= r_v[1];
                r_v[1]  <= r_v[0];
                r_v[0]  <= t1 + t2;
                r_rnd   <= r_rnd + 6'd1;
                if (r_rnd == 6'd63) begin
                    r_busy <= 1'b0;
                    r_add  <= 1'b1;
                end
            end else if (r_add) begin
                for (int i = 0; i < 8; i++) r_h[i] <= r_h[i] + r_v[i];
            end
        end
    end

    assign o_done  = r_add;
    assign o_chain = r_h;

endmodule
